// ----- design/rxcw_pkg.sv -----
// types and constants shared by the riff/xwma chunk walker
package rxcw_pkg;

    // parse phase of the walker
    typedef enum logic [1:0] {
        PH_SIG  = 2'd0,
        PH_HDR  = 2'd1,
        PH_WALK = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    // kind of result record
    typedef enum logic [1:0] {
        KIND_FMT  = 2'd0,
        KIND_DPDS = 2'd1,
        KIND_DATA = 2'd2,
        KIND_END  = 2'd3
    } kind_t;

    // end status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIG   = 3'd1,
        ST_NOT_XWMA  = 3'd2,
        ST_BAD_SIZE  = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    // fourcc codes as read little endian, plain and byte swapped
    localparam logic [31:0] CC_RIFF    = 32'h52494646;
    localparam logic [31:0] CC_RIFF_SW = 32'h46464952;
    localparam logic [31:0] CC_XWMA    = 32'h58574D41;
    localparam logic [31:0] CC_XWMA_SW = 32'h414D5758;
    localparam logic [31:0] CC_FMT     = 32'h666D7420;
    localparam logic [31:0] CC_FMT_SW  = 32'h20746D66;
    localparam logic [31:0] CC_DPDS    = 32'h64706473;
    localparam logic [31:0] CC_DPDS_SW = 32'h73647064;
    localparam logic [31:0] CC_DATA    = 32'h64617461;
    localparam logic [31:0] CC_DATA_SW = 32'h61746164;

    // sizes and positions in the file
    localparam logic [31:0] FMT_MIN      = 32'd18;
    localparam logic [31:0] MIN_BUFFER   = 32'd12;
    localparam logic [31:0] FIRST_CHUNK  = 32'h0000000C;
    localparam logic [31:0] HDR_LEN      = 32'd8;
    localparam logic [31:0] FIRST_BODY   = FIRST_CHUNK + HDR_LEN;
    localparam logic [3:0]  SIG_LAST_IDX = 4'd3;
    localparam logic [3:0]  HDR_LAST_IDX = 4'd11;
    localparam logic [2:0]  CHDR_LAST    = 3'd7;

    // one result record
    typedef struct packed {
        kind_t       kind;
        logic [31:0] off;
        logic [31:0] size;
        status_t     status;
        logic        last;
    } rec_t;

endpackage

// ----- design/riff_xwma_chunk_walker.sv -----
// riff/xwma chunk walker: byte stream parser with a small result queue
//
// Bytes of a RIFF file enter on s_axis, one item per byte, tuser set on the
// first byte of a file. The walker checks the signature (either byte order),
// the XWMA type and the RIFF size against buffer_size, then walks the chunk
// headers and reports fmt, dpds and data chunks and one end status on
// m_axis. tuser carries the record kind, tlast marks the last record caused
// by one byte.
// Each byte is parsed in the cycle it is accepted: the state registers and
// a seven-byte header shift line feed one add-and-compare stage whose
// records are registered straight into an OUT_DEPTH entry output queue.
// One byte is taken every cycle while the queue has room for two records
// (a byte makes at most two). When the receiver stalls, the queue fills
// and s_axis_tready drops; no record is lost. Reset empties the queue, sets
// buffer_size to zero and returns the parser to the signature phase.
// buffer_size is written through cfg_we / cfg_wdata; the user must do so only
// while the block is idle, as the block itself does not enforce this.
module riff_xwma_chunk_walker #(
    parameter int OUT_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // input bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] start_of_file
    // result records
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] body_offset, [63:32] body_size,
                                        // [66:64] status, zero fill above
    output logic [1:0]  m_axis_tuser,   // [1:0] record_kind
    output logic        m_axis_tlast,   // last_result
    // buffer_size register
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    localparam int PW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CW = $clog2(OUT_DEPTH + 1);

    // state registers
    rxcw_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic        swapped_reg, swapped_next;
    logic [55:0] hdr_reg;
    logic [31:0] skip_reg, skip_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] body_at_reg, body_at_next;
    logic [31:0] lim_reg, lim_next;
    logic [31:0] buf_size_reg;

    // output queue
    rxcw_pkg::rec_t  fifo_mem [OUT_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg, wr_ptr1;
    logic [CW-1:0]   cnt_q_reg;
    logic [1:0]      push_n;
    rxcw_pkg::rec_t  res0, res1;

    // parse signals
    logic             accept, pop;
    rxcw_pkg::phase_t eff_phase;
    logic [3:0]       eff_idx;
    logic [63:0]      word;
    logic [31:0]      lo, hi;
    logic             short_buf, sig_plain, sig_sw, xwma_ok, too_big, tiny_riff;
    logic             walk_hdr_byte, chunk_end, match_fmt, match_dpds, match_data;
    logic [32:0]      after;
    logic             overflow, walk_over;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = m_axis_tvalid && m_axis_tready;

    // start of file restarts the parse with this byte as byte zero
    assign eff_phase = s_axis_tuser ? rxcw_pkg::PH_SIG : phase_reg;
    assign eff_idx   = s_axis_tuser ? 4'd0 : idx_reg;

    // last eight bytes including the current one, oldest in the low byte
    assign word = {s_axis_tdata, hdr_reg};
    assign lo   = word[31:0];
    assign hi   = word[63:32];

    // header checks
    assign short_buf = (eff_idx == 4'd0) && (buf_size_reg < rxcw_pkg::MIN_BUFFER);
    assign sig_plain = (hi == rxcw_pkg::CC_RIFF);
    assign sig_sw    = (hi == rxcw_pkg::CC_RIFF_SW);
    assign xwma_ok   = swapped_reg ? (hi == rxcw_pkg::CC_XWMA_SW)
                                   : (hi == rxcw_pkg::CC_XWMA);
    assign too_big   = ({1'b0, lo} + {1'b0, rxcw_pkg::HDR_LEN}) > {1'b0, buf_size_reg};
    assign tiny_riff = (lo <= rxcw_pkg::FIRST_CHUNK);

    // chunk header checks
    assign walk_hdr_byte = (eff_phase == rxcw_pkg::PH_WALK) && (skip_reg == 32'd0);
    assign chunk_end     = walk_hdr_byte && (cnt_reg == rxcw_pkg::CHDR_LAST);
    assign match_fmt  = (swapped_reg ? (lo == rxcw_pkg::CC_FMT_SW)
                                     : (lo == rxcw_pkg::CC_FMT))
                        && (hi >= rxcw_pkg::FMT_MIN);
    assign match_dpds = (swapped_reg ? (lo == rxcw_pkg::CC_DPDS_SW)
                                     : (lo == rxcw_pkg::CC_DPDS))
                        && (hi[1:0] == 2'b00);
    assign match_data = swapped_reg ? (lo == rxcw_pkg::CC_DATA_SW)
                                    : (lo == rxcw_pkg::CC_DATA);
    assign after     = {1'b0, body_at_reg} + {1'b0, hi};
    assign overflow  = after[32];
    // position + 8 >= riff size + 8, both sides shifted down by eight
    assign walk_over = (after >= {1'b0, lim_reg});

    // next parse phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            phase_next = eff_phase;
            unique case (eff_phase)
                rxcw_pkg::PH_SIG:
                begin
                    if (short_buf)
                        phase_next = rxcw_pkg::PH_DONE;
                    else if (eff_idx == rxcw_pkg::SIG_LAST_IDX)
                        phase_next = (sig_plain || sig_sw) ? rxcw_pkg::PH_HDR
                                                           : rxcw_pkg::PH_DONE;
                end
                rxcw_pkg::PH_HDR:
                begin
                    if (eff_idx == rxcw_pkg::HDR_LAST_IDX)
                    begin
                        if (!xwma_ok || too_big || tiny_riff)
                            phase_next = rxcw_pkg::PH_DONE;
                        else
                            phase_next = rxcw_pkg::PH_WALK;
                    end
                end
                rxcw_pkg::PH_WALK:
                begin
                    if (chunk_end && (overflow || walk_over))
                        phase_next = rxcw_pkg::PH_DONE;
                end
                rxcw_pkg::PH_DONE:
                begin
                    phase_next = rxcw_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = rxcw_pkg::PH_DONE;
                end
            endcase
        end
    end

    // result records for the accepted byte
    always_comb
    begin
        res0   = '{kind: rxcw_pkg::KIND_END, off: 32'd0, size: 32'd0,
                   status: rxcw_pkg::ST_OK, last: 1'b1};
        res1   = res0;
        push_n = 2'd0;
        if (accept)
        begin
            unique case (eff_phase)
                rxcw_pkg::PH_SIG:
                begin
                    if (short_buf)
                    begin
                        res0.status = rxcw_pkg::ST_BAD_SIZE;
                        push_n      = 2'd1;
                    end
                    else if ((eff_idx == rxcw_pkg::SIG_LAST_IDX) && !sig_plain && !sig_sw)
                    begin
                        res0.status = rxcw_pkg::ST_BAD_SIG;
                        push_n      = 2'd1;
                    end
                end
                rxcw_pkg::PH_HDR:
                begin
                    if (eff_idx == rxcw_pkg::HDR_LAST_IDX)
                    begin
                        priority if (!xwma_ok)
                            res0.status = rxcw_pkg::ST_NOT_XWMA;
                        else if (too_big)
                            res0.status = rxcw_pkg::ST_BAD_SIZE;
                        else
                            res0.status = rxcw_pkg::ST_OK;
                        if (!xwma_ok || too_big || tiny_riff)
                            push_n = 2'd1;
                    end
                end
                rxcw_pkg::PH_WALK:
                begin
                    if (chunk_end)
                    begin
                        if (overflow)
                        begin
                            res0.status = rxcw_pkg::ST_OVERFLOW;
                            push_n      = 2'd1;
                        end
                        else if (match_fmt || match_dpds || match_data)
                        begin
                            priority if (match_fmt)
                                res0.kind = rxcw_pkg::KIND_FMT;
                            else if (match_dpds)
                                res0.kind = rxcw_pkg::KIND_DPDS;
                            else
                                res0.kind = rxcw_pkg::KIND_DATA;
                            res0.off  = body_at_reg;
                            res0.size = hi;
                            res0.last = !walk_over;
                            push_n    = walk_over ? 2'd2 : 2'd1;
                        end
                        else if (walk_over)
                        begin
                            push_n = 2'd1;
                        end
                    end
                end
                rxcw_pkg::PH_DONE:
                begin
                    push_n = 2'd0;
                end
                default:
                begin
                    push_n = 2'd0;
                end
            endcase
        end
    end

    // counters and header bookkeeping
    always_comb
    begin
        idx_next     = idx_reg;
        swapped_next = swapped_reg;
        skip_next    = skip_reg;
        cnt_next     = cnt_reg;
        body_at_next = body_at_reg;
        lim_next     = lim_reg;
        if (accept)
        begin
            idx_next = (eff_idx == rxcw_pkg::HDR_LAST_IDX) ? eff_idx : eff_idx + 4'd1;
            if (s_axis_tuser)
                swapped_next = 1'b0;
            if ((eff_phase == rxcw_pkg::PH_SIG) && (eff_idx == rxcw_pkg::SIG_LAST_IDX))
                swapped_next = sig_sw;
            if ((eff_phase == rxcw_pkg::PH_HDR) && (eff_idx == rxcw_pkg::HDR_LAST_IDX))
            begin
                lim_next     = lo;
                body_at_next = rxcw_pkg::FIRST_BODY;
                skip_next    = 32'd0;
                cnt_next     = 3'd0;
            end
            if (eff_phase == rxcw_pkg::PH_WALK)
            begin
                if (!walk_hdr_byte)
                    skip_next = skip_reg - 32'd1;
                else if (chunk_end)
                begin
                    skip_next    = hi;
                    cnt_next     = 3'd0;
                    body_at_next = after[31:0] + rxcw_pkg::HDR_LEN;
                end
                else
                    cnt_next = cnt_reg + 3'd1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= rxcw_pkg::PH_SIG;
            idx_reg      <= 4'd0;
            swapped_reg  <= 1'b0;
            skip_reg     <= 32'd0;
            cnt_reg      <= 3'd0;
            body_at_reg  <= rxcw_pkg::FIRST_BODY;
            lim_reg      <= 32'd0;
            buf_size_reg <= 32'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            swapped_reg  <= swapped_next;
            skip_reg     <= skip_next;
            cnt_reg      <= cnt_next;
            body_at_reg  <= body_at_next;
            lim_reg      <= lim_next;
            if (cfg_we)
                buf_size_reg <= cfg_wdata;
        end
    end

    // header byte shift line
    always_ff @(posedge clk)
    begin
        if (accept)
            hdr_reg <= word[63:8];
    end

    // output queue write side
    assign wr_ptr1 = (wr_ptr_reg == PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_mem[wr_ptr_reg] <= res0;
        if (push_n == 2'd2)
            fifo_mem[wr_ptr1] <= res1;
    end

    // output queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_q_reg  <= '0;
        end
        else
        begin
            if (push_n == 2'd1)
                wr_ptr_reg <= wr_ptr1;
            else if (push_n == 2'd2)
                wr_ptr_reg <= (wr_ptr1 == PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr1 + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(OUT_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PW'(1);
            cnt_q_reg <= cnt_q_reg + CW'(push_n) - CW'(pop);
        end
    end

    // handshake and output payload
    assign s_axis_tready = (cnt_q_reg <= CW'(OUT_DEPTH - 2));
    assign m_axis_tvalid = (cnt_q_reg != '0);
    assign m_axis_tdata  = {5'd0, fifo_mem[rd_ptr_reg].status,
                            fifo_mem[rd_ptr_reg].size, fifo_mem[rd_ptr_reg].off};
    assign m_axis_tuser  = fifo_mem[rd_ptr_reg].kind;
    assign m_axis_tlast  = fifo_mem[rd_ptr_reg].last;

    // queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_q_reg <= CW'(OUT_DEPTH))
        else $error("output queue overfilled");

    // a finished parse adds nothing to the queue until the next file
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_axis_tuser && (phase_reg == rxcw_pkg::PH_DONE))
        |=> (cnt_q_reg <= $past(cnt_q_reg)))
        else $error("record produced after end of parse");

    // the walk only runs for a riff body that holds at least one chunk header
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rxcw_pkg::PH_WALK) |-> (lim_reg > rxcw_pkg::FIRST_CHUNK))
        else $error("walk entered with too small a riff size");

    // chunk records always carry an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != rxcw_pkg::KIND_END))
        |-> (m_axis_tdata[66:64] == rxcw_pkg::ST_OK))
        else $error("chunk record with error status");

endmodule

// ----- dv/riff_xwma_chunk_walker_tb.sv -----
// testbench for the riff/xwma chunk walker: directed table, random files, self-checking
`timescale 1ns / 1ps

module riff_xwma_chunk_walker_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1020;

    // how a directed row is checked
    localparam int CHK_MODEL = 0;
    localparam int CHK_NONE  = 1;
    localparam int CHK_END   = 2;

    typedef struct {
        bit                cfg_now;
        logic [31:0]       cfg_val;
        logic [7:0]        data;
        logic              sof;
        int                chk;
        rxcw_pkg::status_t st;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] data_byte
    logic        s_axis_tuser;    // [0] start_of_file
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;    // [31:0] body_offset, [63:32] body_size, [66:64] status
    logic [1:0]  m_axis_tuser;    // [1:0] record_kind
    logic        m_axis_tlast;    // last_result
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    // parser state mirrored by the testbench
    logic [31:0]       buf_size;
    logic [31:0]       p_index;
    rxcw_pkg::phase_t  p_phase;
    bit                p_swapped;
    logic [63:0]       p_hdr;
    logic [31:0]       p_walk_end;
    logic [31:0]       p_next_hdr;

    rxcw_pkg::rec_t    step_recs[$];
    rxcw_pkg::rec_t    due_records[$];
    logic [7:0]        file_bytes[$];
    logic [7:0]        chunk_bytes[$];
    bit                file_sof;
    dir_row_t          dir_rows[$];

    int          fail_count = 0;
    int          item_count = 0;
    int          cycle_count = 0;
    bit          calm = 1'b0;
    int          calm_left = 0;
    int          stall_left = 0;

    riff_xwma_chunk_walker uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] swap32(logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // fourcc as the signature order says it is read
    function automatic logic [31:0] cc_read(logic [31:0] le);
        return p_swapped ? swap32(le) : le;
    endfunction

    function automatic rxcw_pkg::rec_t mk_rec(rxcw_pkg::kind_t k, logic [31:0] o,
                                              logic [31:0] s, rxcw_pkg::status_t st);
        rxcw_pkg::rec_t r;
        r.kind   = k;
        r.off    = o;
        r.size   = s;
        r.status = st;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic void clear_parse();
        p_index    = '0;
        p_phase    = rxcw_pkg::PH_SIG;
        p_swapped  = 1'b0;
        p_hdr      = '0;
        p_walk_end = '0;
        p_next_hdr = rxcw_pkg::FIRST_CHUNK;
    endfunction

    // advance the mirrored parser by one byte, records land in step_recs
    task automatic parse_byte(input logic [7:0] b, input logic sof);
        logic [31:0] idx, sig, rsize, rtype, ctype, csize, body, d;
        logic [32:0] after;
        step_recs.delete();
        if (sof)
            clear_parse();
        idx = p_index;
        case (p_phase)
            rxcw_pkg::PH_SIG:
            begin
                p_hdr = {b, p_hdr[63:8]};
                if (idx == 0 && buf_size < rxcw_pkg::MIN_BUFFER)
                begin
                    step_recs.push_back(mk_rec(rxcw_pkg::KIND_END, '0, '0,
                                               rxcw_pkg::ST_BAD_SIZE));
                    p_phase = rxcw_pkg::PH_DONE;
                end
                else if (idx == 3)
                begin
                    sig = p_hdr[63:32];
                    if (sig == rxcw_pkg::CC_RIFF)
                    begin
                        p_swapped = 1'b0;
                        p_phase   = rxcw_pkg::PH_HDR;
                    end
                    else if (sig == rxcw_pkg::CC_RIFF_SW)
                    begin
                        p_swapped = 1'b1;
                        p_phase   = rxcw_pkg::PH_HDR;
                    end
                    else
                    begin
                        step_recs.push_back(mk_rec(rxcw_pkg::KIND_END, '0, '0,
                                                   rxcw_pkg::ST_BAD_SIG));
                        p_phase = rxcw_pkg::PH_DONE;
                    end
                end
            end
            rxcw_pkg::PH_HDR:
            begin
                p_hdr = {b, p_hdr[63:8]};
                if (idx == 11)
                begin
                    rsize = p_hdr[31:0];
                    rtype = cc_read(p_hdr[63:32]);
                    if (rtype != rxcw_pkg::CC_XWMA)
                    begin
                        step_recs.push_back(mk_rec(rxcw_pkg::KIND_END, '0, '0,
                                                   rxcw_pkg::ST_NOT_XWMA));
                        p_phase = rxcw_pkg::PH_DONE;
                    end
                    else if (({1'b0, rsize} + 33'd8) > {1'b0, buf_size})
                    begin
                        step_recs.push_back(mk_rec(rxcw_pkg::KIND_END, '0, '0,
                                                   rxcw_pkg::ST_BAD_SIZE));
                        p_phase = rxcw_pkg::PH_DONE;
                    end
                    else
                    begin
                        p_walk_end = rsize + 32'd8;
                        p_next_hdr = rxcw_pkg::FIRST_CHUNK;
                        p_hdr      = '0;
                        p_phase    = rxcw_pkg::PH_WALK;
                        if (rxcw_pkg::FIRST_BODY >= p_walk_end)
                        begin
                            step_recs.push_back(mk_rec(rxcw_pkg::KIND_END, '0, '0,
                                                       rxcw_pkg::ST_OK));
                            p_phase = rxcw_pkg::PH_DONE;
                        end
                    end
                end
            end
            rxcw_pkg::PH_WALK:
            begin
                d = idx - p_next_hdr;
                if (d < 8)
                begin
                    p_hdr = {b, p_hdr[63:8]};
                    if (d == 7)
                    begin
                        ctype = cc_read(p_hdr[31:0]);
                        csize = p_hdr[63:32];
                        body  = p_next_hdr + 32'd8;
                        after = {1'b0, body} + {1'b0, csize};
                        p_hdr = '0;
                        if (after[32])
                        begin
                            step_recs.push_back(mk_rec(rxcw_pkg::KIND_END, '0, '0,
                                                       rxcw_pkg::ST_OVERFLOW));
                            p_phase = rxcw_pkg::PH_DONE;
                        end
                        else
                        begin
                            if (ctype == rxcw_pkg::CC_FMT && csize >= rxcw_pkg::FMT_MIN)
                                step_recs.push_back(mk_rec(rxcw_pkg::KIND_FMT, body, csize,
                                                           rxcw_pkg::ST_OK));
                            else if (ctype == rxcw_pkg::CC_DPDS && csize[1:0] == 2'b00)
                                step_recs.push_back(mk_rec(rxcw_pkg::KIND_DPDS, body, csize,
                                                           rxcw_pkg::ST_OK));
                            else if (ctype == rxcw_pkg::CC_DATA)
                                step_recs.push_back(mk_rec(rxcw_pkg::KIND_DATA, body, csize,
                                                           rxcw_pkg::ST_OK));
                            p_next_hdr = after[31:0];
                            if (({1'b0, after} + 34'd8) >= {2'b0, p_walk_end})
                            begin
                                step_recs.push_back(mk_rec(rxcw_pkg::KIND_END, '0, '0,
                                                           rxcw_pkg::ST_OK));
                                p_phase = rxcw_pkg::PH_DONE;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        p_index = idx + 32'd1;
        if (step_recs.size() > 0)
            step_recs[step_recs.size() - 1].last = 1'b1;
    endtask

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // send one item; entered and left at a falling edge
    task automatic push_byte(input logic [7:0] b, input logic sof, input int chk_mode,
                             input rxcw_pkg::status_t st);
        int             g;
        rxcw_pkg::rec_t want;
        g = pick_gap();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= sof;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        parse_byte(b, sof);
        item_count++;
        if (chk_mode == CHK_MODEL)
        begin
            foreach (step_recs[i])
                due_records.push_back(step_recs[i]);
        end
        else if (chk_mode == CHK_END)
        begin
            want      = mk_rec(rxcw_pkg::KIND_END, '0, '0, st);
            want.last = 1'b1;
            due_records.push_back(want);
        end
        @(negedge clk);
    endtask

    // stop sending until every record is out, then let the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (due_records.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_size(input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        buf_size  = v;
    endtask

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 32'hFFFF_FFFF;
        if (r < 45)
            return $urandom;
        if (r < 50)
            return 32'd0;
        if (r < 55)
            return 32'd11;
        if (r < 60)
            return rxcw_pkg::MIN_BUFFER;
        if (r < 72)
            return $urandom_range(13, 100);
        return $urandom_range(100, 2000);
    endfunction

    // fourcc in file order; rev writes it for the little endian reading
    task automatic put_cc(ref logic [7:0] q[$], input logic [31:0] cc, input bit rev);
        if (rev)
        begin
            q.push_back(cc[7:0]);
            q.push_back(cc[15:8]);
            q.push_back(cc[23:16]);
            q.push_back(cc[31:24]);
        end
        else
        begin
            q.push_back(cc[31:24]);
            q.push_back(cc[23:16]);
            q.push_back(cc[15:8]);
            q.push_back(cc[7:0]);
        end
    endtask

    task automatic put32(ref logic [7:0] q[$], input logic [31:0] v);
        q.push_back(v[7:0]);
        q.push_back(v[15:8]);
        q.push_back(v[23:16]);
        q.push_back(v[31:24]);
    endtask

    // build one file: mostly well formed with random chunks, some noise
    task automatic build_file();
        int          r, t, k, nch, pos;
        logic [31:0] csize, rsize, cc, exact;
        bit          rev, stop;
        file_bytes.delete();
        chunk_bytes.delete();
        file_sof = ($urandom_range(0, 19) != 0);
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            repeat ($urandom_range(1, 16)) file_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        rev  = ($urandom_range(0, 3) == 0);
        pos  = 12;
        stop = 1'b0;
        nch  = $urandom_range(0, 4);
        // chunk list
        for (k = 0; k < nch && !stop; k++)
        begin
            t = $urandom_range(0, 99);
            if (t < 30)
            begin
                cc    = rxcw_pkg::CC_FMT;
                csize = ($urandom_range(0, 3) != 0) ? $urandom_range(18, 30)
                                                    : $urandom_range(0, 17);
            end
            else if (t < 50)
            begin
                cc    = rxcw_pkg::CC_DPDS;
                csize = ($urandom_range(0, 3) != 0) ? 4 * $urandom_range(0, 6)
                                                    : $urandom_range(0, 25);
            end
            else if (t < 75)
            begin
                cc    = rxcw_pkg::CC_DATA;
                csize = $urandom_range(0, 32);
            end
            else if (t < 88)
            begin
                cc    = $urandom;
                csize = $urandom_range(0, 16);
            end
            else if (t < 94)
            begin
                // body end past 32 bits
                cc    = rxcw_pkg::CC_DATA;
                csize = 32'hFFFF_FFFF - $urandom_range(0, 15);
                stop  = 1'b1;
            end
            else
            begin
                // body runs past the walk end
                cc    = ($urandom_range(0, 1) == 0) ? rxcw_pkg::CC_DATA : rxcw_pkg::CC_FMT;
                csize = $urandom_range(100, 100000);
                stop  = 1'b1;
            end
            put_cc(chunk_bytes, cc, rev);
            put32(chunk_bytes, csize);
            pos += 8;
            if (!stop)
            begin
                repeat (csize) chunk_bytes.push_back(8'($urandom_range(0, 255)));
                pos += int'(csize);
            end
        end
        // riff size: mostly exact, sometimes short, long or wild
        exact = 32'(pos - 8);
        r = $urandom_range(0, 99);
        if (r < 75)
            rsize = exact;
        else if (r < 83)
        begin
            t = $urandom_range(1, 12);
            rsize = (exact > 32'(t)) ? exact - 32'(t) : 32'd0;
        end
        else if (r < 88)
            rsize = $urandom_range(0, 12);
        else if (r < 94)
            rsize = exact + $urandom_range(1, 20);
        else
            rsize = $urandom;
        // riff header
        if ($urandom_range(0, 19) == 0)
            repeat (4) file_bytes.push_back(8'($urandom_range(0, 255)));
        else
            put_cc(file_bytes, rxcw_pkg::CC_RIFF, rev);
        put32(file_bytes, rsize);
        if ($urandom_range(0, 14) == 0)
            put_cc(file_bytes, ($urandom_range(0, 1) == 0) ? rxcw_pkg::CC_FMT : $urandom, rev);
        else
            put_cc(file_bytes, rxcw_pkg::CC_XWMA, rev);
        foreach (chunk_bytes[i])
            file_bytes.push_back(chunk_bytes[i]);
        repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // cycle count, run limit and calm stretches
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (calm_left == 0)
        begin
            calm      <= ($urandom_range(0, 3) == 0);
            calm_left <= $urandom_range(50, 400);
        end
        else
            calm_left <= calm_left - 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** riff_xwma_chunk_walker: FAILED **");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin : rx_side
        int hold;
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            hold = pick_gap();
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left    <= hold - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // compare each record with the oldest one due
    always @(posedge clk)
    begin : rec_check
        rxcw_pkg::rec_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_records.size() == 0)
            begin
                $error("record_kind: expected none, got %0d", m_axis_tuser);
                fail_count++;
            end
            else
            begin
                want = due_records.pop_front();
                if (m_axis_tuser !== want.kind)
                begin
                    $error("record_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[31:0] !== want.off)
                begin
                    $error("body_offset: expected %h, got %h", want.off, m_axis_tdata[31:0]);
                    fail_count++;
                end
                if (m_axis_tdata[63:32] !== want.size)
                begin
                    $error("body_size: expected %h, got %h", want.size, m_axis_tdata[63:32]);
                    fail_count++;
                end
                if (m_axis_tdata[66:64] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tdata[66:64]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_result: expected %0d, got %0d", want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        buf_size      = '0;
        clear_parse();

        // directed rows: short buffer with no start mark, ignored byte, limits
        dir_rows.push_back('{0, 32'd0,         8'h52, 1'b0, CHK_END,   rxcw_pkg::ST_BAD_SIZE});
        dir_rows.push_back('{0, 32'd0,         8'hFF, 1'b0, CHK_NONE,  rxcw_pkg::ST_OK});
        dir_rows.push_back('{1, 32'd11,        8'h00, 1'b1, CHK_END,   rxcw_pkg::ST_BAD_SIZE});
        // "RIFX" signature
        dir_rows.push_back('{1, 32'hFFFF_FFFF, 8'h52, 1'b1, CHK_NONE,  rxcw_pkg::ST_OK});
        dir_rows.push_back('{0, 32'd0,         8'h49, 1'b0, CHK_NONE,  rxcw_pkg::ST_OK});
        dir_rows.push_back('{0, 32'd0,         8'h46, 1'b0, CHK_NONE,  rxcw_pkg::ST_OK});
        dir_rows.push_back('{0, 32'd0,         8'h58, 1'b0, CHK_END,   rxcw_pkg::ST_BAD_SIG});
        // reversed signature, so "XWMA" in file order is the wrong type
        dir_rows.push_back('{0, 32'd0,         8'h46, 1'b1, CHK_MODEL, rxcw_pkg::ST_OK});
        dir_rows.push_back('{0, 32'd0,         8'h46, 1'b0, CHK_MODEL, rxcw_pkg::ST_OK});
        dir_rows.push_back('{0, 32'd0,         8'h49, 1'b0, CHK_MODEL, rxcw_pkg::ST_OK});
        dir_rows.push_back('{0, 32'd0,         8'h52, 1'b0, CHK_MODEL, rxcw_pkg::ST_OK});
        dir_rows.push_back('{0, 32'd0,         8'hFF, 1'b0, CHK_MODEL, rxcw_pkg::ST_OK});
        dir_rows.push_back('{0, 32'd0,         8'h00, 1'b0, CHK_MODEL, rxcw_pkg::ST_OK});
        dir_rows.push_back('{0, 32'd0,         8'hFF, 1'b0, CHK_MODEL, rxcw_pkg::ST_OK});
        dir_rows.push_back('{0, 32'd0,         8'h00, 1'b0, CHK_MODEL, rxcw_pkg::ST_OK});
        dir_rows.push_back('{0, 32'd0,         8'h58, 1'b0, CHK_MODEL, rxcw_pkg::ST_OK});
        dir_rows.push_back('{0, 32'd0,         8'h57, 1'b0, CHK_MODEL, rxcw_pkg::ST_OK});
        dir_rows.push_back('{0, 32'd0,         8'h4D, 1'b0, CHK_MODEL, rxcw_pkg::ST_OK});
        dir_rows.push_back('{0, 32'd0,         8'h41, 1'b0, CHK_END,   rxcw_pkg::ST_NOT_XWMA});

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg_now)
            begin
                settle();
                write_size(dir_rows[i].cfg_val);
            end
            push_byte(dir_rows[i].data, dir_rows[i].sof, dir_rows[i].chk, dir_rows[i].st);
        end

        // random files, with size changes and full drains between some
        settle();
        write_size(32'hFFFF_FFFF);
        while (item_count < ITEM_TARGET)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                settle();
                write_size(pick_size());
            end
            else if ($urandom_range(0, 9) == 0)
                settle();
            build_file();
            foreach (file_bytes[i])
                push_byte(file_bytes[i], (i == 0) && file_sof, CHK_MODEL, rxcw_pkg::ST_OK);
        end

        // drain and let any stray record show up
        settle();
        repeat (16) @(negedge clk);
        if (fail_count == 0)
            $display("** riff_xwma_chunk_walker: PASSED **");
        else
            $display("** riff_xwma_chunk_walker: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
design/rxcw_pkg.sv
design/riff_xwma_chunk_walker.sv
dv/riff_xwma_chunk_walker_tb.sv
